// ===== hw/rtl/pfr_pkg.sv =====
// Shared types and constants for the PWM fade ramp controller.
package pfr_pkg;

    localparam int MODE_W = 2;
    localparam int CHAN_W = 2;
    localparam int LVL_IN_W = 9;
    localparam int STEP_W = 9;
    localparam int CMP_W = 8;

    localparam logic [STEP_W-1:0] STEP_RESET = 9'd2;

    localparam int CMP_KNEE = 10;
    localparam int CMP_OFFSET = 2;

    localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FADE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECODE = 3'b010,
        ST_SCAN   = 3'b100
    } pfr_state_t;

    typedef struct packed {
        logic latch;
        logic direct;
        logic fade;
        logic scan_start;
        logic step;
        logic advance;
    } pfr_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              chan_ok;
        logic              cur_active;
        logic              at_end;
        logic              more_active;
        logic              slot_free;
    } pfr_status_t;

endpackage

// ===== hw/rtl/pfr_in_if.sv =====
// Request channel carrying one mode, channel and level per request.
interface pfr_in_if
    import pfr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [CHAN_W-1:0]   channel;
    logic [LVL_IN_W-1:0] level;

    modport source (output valid, output mode, output channel, output level, input ready);
    modport sink (input valid, input mode, input channel, input level, output ready);
endinterface

// ===== hw/rtl/pfr_out_if.sv =====
// Result channel carrying one compare update, with its channel, enable and last flag, per transfer.
interface pfr_out_if
    import pfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_channel;
    logic [CMP_W-1:0]  compare_value;
    logic              output_enable;
    logic              last;

    modport source (output valid, output out_channel, output compare_value,
                    output output_enable, output last, input ready);
    modport sink (input valid, input out_channel, input compare_value,
                  input output_enable, input last, output ready);
endinterface

// ===== hw/rtl/pfr_ctrl.sv =====
// Controller state machine that sequences set operations and the tick scan.
module pfr_ctrl
    import pfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pfr_status_t status,
    output pfr_cmd_t    cmd
);

    pfr_state_t state_reg;
    pfr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.mode)
                    MODE_DIRECT:
                    begin
                        if (!status.chan_ok)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (status.slot_free)
                        begin
                            cmd.direct = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_FADE:
                    begin
                        cmd.fade = status.chan_ok;
                        state_next = ST_IDLE;
                    end
                    MODE_TICK:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (status.cur_active)
                begin
                    if (status.slot_free)
                    begin
                        cmd.step = 1'b1;
                        if (status.more_active)
                        begin
                            cmd.advance = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (status.at_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pfr_dp.sv =====
// Datapath holding channel levels, ramp flags, the step unit and the result register.
module pfr_dp
    import pfr_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int LEVEL_BITS = 9
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [STEP_W-1:0]   cfg_wdata,
    input  logic [MODE_W-1:0]   mode,
    input  logic [CHAN_W-1:0]   channel,
    input  logic [LVL_IN_W-1:0] level,
    input  pfr_cmd_t            cmd,
    output pfr_status_t         status,
    pfr_out_if.source           result
);

    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = (LEVEL_BITS > STEP_W) ? LEVEL_BITS : STEP_W;

    logic [STEP_W-1:0]     step_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [CHAN_W-1:0]     chan_reg;
    logic [LEVEL_BITS-1:0] lvl_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         idx_next;

    logic [LEVEL_BITS-1:0]   cur_reg [NUM_CHANNELS];
    logic [LEVEL_BITS-1:0]   cur_next [NUM_CHANNELS];
    logic [LEVEL_BITS-1:0]   tgt_reg [NUM_CHANNELS];
    logic [LEVEL_BITS-1:0]   tgt_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] act_reg;
    logic [NUM_CHANNELS-1:0] act_next;
    logic [NUM_CHANNELS-1:0] down_reg;
    logic [NUM_CHANNELS-1:0] down_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAN_W-1:0] out_chan_reg;
    logic [CMP_W-1:0]  out_cmp_reg;
    logic              out_oe_reg;
    logic              out_last_reg;

    logic [IW-1:0]         ch_idx;
    logic [STEP_W-1:0]     step_eff;
    logic [CW-1:0]         cur_w;
    logic [CW-1:0]         tgt_w;
    logic [CW-1:0]         diff_w;
    logic [CW-1:0]         d_w;
    logic [CW-1:0]         new_w;
    logic [LEVEL_BITS-1:0] new_lvl;
    logic [LEVEL_BITS-1:0] em_v;
    logic [CMP_W-1:0]      em_cmp;
    logic                  more_active;
    logic                  load;

    assign ch_idx = IW'(chan_reg);
    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    assign cur_w = CW'(cur_reg[idx_reg]);
    assign tgt_w = CW'(tgt_reg[idx_reg]);

    always_comb
    begin
        if (down_reg[idx_reg])
        begin
            diff_w = (cur_w >= tgt_w) ? (cur_w - tgt_w) : '0;
        end
        else
        begin
            diff_w = (tgt_w >= cur_w) ? (tgt_w - cur_w) : '0;
        end
        d_w = (diff_w > CW'(step_eff)) ? CW'(step_eff) : diff_w;
        new_w = down_reg[idx_reg] ? (cur_w - d_w) : (cur_w + d_w);
    end

    assign new_lvl = LEVEL_BITS'(new_w);

    assign em_v = cmd.direct ? lvl_reg : new_lvl;
    assign em_cmp = (em_v > LEVEL_BITS'(CMP_KNEE))
                    ? CMP_W'((em_v - LEVEL_BITS'(CMP_OFFSET)) >> 1)
                    : CMP_W'(em_v >> 1);

    always_comb
    begin
        more_active = 1'b0;
        for (int j = 0; j < NUM_CHANNELS; j++)
        begin
            if (act_reg[j] && (j > int'(idx_reg)))
            begin
                more_active = 1'b1;
            end
        end
    end

    assign load = cmd.direct || cmd.step;

    always_comb
    begin
        status.mode = mode_reg;
        status.chan_ok = int'(chan_reg) < NUM_CHANNELS;
        status.cur_active = act_reg[idx_reg];
        status.at_end = idx_reg == IW'(NUM_CHANNELS - 1);
        status.more_active = more_active;
        status.slot_free = !out_valid_reg || result.ready;
    end

    always_comb
    begin
        cur_next = cur_reg;
        tgt_next = tgt_reg;
        act_next = act_reg;
        down_next = down_reg;
        if (cmd.direct)
        begin
            cur_next[ch_idx] = lvl_reg;
            tgt_next[ch_idx] = lvl_reg;
            act_next[ch_idx] = 1'b0;
        end
        if (cmd.fade)
        begin
            tgt_next[ch_idx] = lvl_reg;
            if (cur_reg[ch_idx] == lvl_reg)
            begin
                act_next[ch_idx] = 1'b0;
            end
            else
            begin
                down_next[ch_idx] = cur_reg[ch_idx] > lvl_reg;
                act_next[ch_idx] = 1'b1;
            end
        end
        if (cmd.step)
        begin
            cur_next[idx_reg] = new_lvl;
            if (new_lvl == tgt_reg[idx_reg])
            begin
                act_next[idx_reg] = 1'b0;
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
        end
        else if (cmd.advance)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            idx_reg <= '0;
            act_reg <= '0;
            down_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            idx_reg <= idx_next;
            act_reg <= act_next;
            down_reg <= down_next;
            out_valid_reg <= out_valid_next;
            cur_reg <= cur_next;
            tgt_reg <= tgt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            chan_reg <= channel;
            lvl_reg <= LEVEL_BITS'(level);
        end
        if (load)
        begin
            out_chan_reg <= cmd.direct ? chan_reg : CHAN_W'(idx_reg);
            out_cmp_reg <= em_cmp;
            out_oe_reg <= em_cmp != '0;
            out_last_reg <= cmd.direct || !more_active;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.out_channel = out_chan_reg;
    assign result.compare_value = out_cmp_reg;
    assign result.output_enable = out_oe_reg;
    assign result.last = out_last_reg;

endmodule

// ===== hw/rtl/pwm_fade_ramp_controller.sv =====
// A direct set to a valid channel is latched, decoded and loaded into the result register once it is free.
// A fade set gives no result.
// A tick scans the channels in order and gives one result per moving channel.
// The controller takes no new request while it decodes a set or scans a tick.
// A stalled result register holds the controller until it drains.
// Reset clears all levels and ramp flags and sets the step size to 2.
module pwm_fade_ramp_controller
    import pfr_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int LEVEL_BITS = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata,
    pfr_in_if.sink            request,
    pfr_out_if.source         result
);

    pfr_cmd_t    cmd;
    pfr_status_t status;
    logic        in_ready;

    assign request.ready = in_ready;

    pfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pfr_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .LEVEL_BITS   (LEVEL_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mode      (request.mode),
        .channel   (request.channel),
        .level     (request.level),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    // A taken request is decoded before the next one is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && in_ready) |=> !in_ready)
        else $error("request accepted while the previous one is still being decoded");

    // The output enable follows the compare value of the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.output_enable == (result.compare_value != '0)))
        else $error("output enable disagrees with compare value");

    // A result is loaded only while the result register is free or being drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.direct) |-> status.slot_free)
        else $error("result register overwritten before it was taken");

endmodule
